>>> hdl/depq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// depq_pkg
// Shared constants and codes for the double-ended priority queue.
// ---------------------------------------------------------------------------
package depq_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int VALUE_W      = 32;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 9;
    localparam int OUT_DATA_W   = 80;

    localparam logic [FUNC_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] OP_POP_MAX = 2'd1;
    localparam logic [FUNC_W-1:0] OP_POP_MIN = 2'd2;
    localparam logic [FUNC_W-1:0] OP_CLEAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;

endpackage
`default_nettype wire

>>> hdl/double_ended_priority_queue_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// double_ended_priority_queue_unit
// Double-ended priority queue over signed 32-bit values held in one memory.
// ---------------------------------------------------------------------------
// The values are kept in ascending order in a circular buffer inside a
// single synchronous memory with a registered read port. The smallest value
// sits at the head pointer and the largest at head plus count minus one, so
// both removals only move the head or shrink the count. An insert walks from
// the tail toward the head, one read and one write-back per larger entry,
// shifting each larger value up by one slot until the place of the new value
// is found; equal values stay ahead of the new one. Afterwards the smallest
// and largest values are read back through the same port. A removal, a clear
// or a dropped insert goes straight to that read-back, which is skipped when
// the queue ends up empty. An insert takes longer the more stored values are
// larger than the new one, bounded by the single memory port that both the
// shift and the read-back use. One request is worked on at a time; the next
// is taken while a finished result still waits in the output register. The
// memory needs no clearing after reset, since only entries inside the live
// window are ever read.
// ---------------------------------------------------------------------------
module double_ended_priority_queue_unit #(
    parameter int CAPACITY = depq_pkg::DEF_CAPACITY
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: value [31:0]
    input  wire logic [depq_pkg::VALUE_W-1:0]      s_tdata,
    // s_tuser: func [1:0]
    input  wire logic [depq_pkg::FUNC_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: largest [31:0], smallest [63:32], occupancy [72:64],
    //          is_empty [73], zero [79:74]
    output logic [depq_pkg::OUT_DATA_W-1:0]        m_tdata,
    // m_tuser: status [1:0]
    output logic [depq_pkg::STATUS_W-1:0]          m_tuser
);
    import depq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0] CAP_W = (AW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_RD_LO   = 3'd3;
    localparam logic [2:0] S_RD_HI   = 3'd4;
    localparam logic [2:0] S_CAP_HI  = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CAP_W)
        begin
            s = s - CAP_W;
        end
        return s[AW-1:0];
    endfunction

    value_t mem [CAPACITY];

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       pos_reg, pos_next;
    value_t              value_reg, value_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    value_t              lo_reg, lo_next;
    value_t              hi_reg, hi_next;
    value_t              rd_data_reg;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    value_t              mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    logic                in_fire;
    logic                out_load;
    logic [OCC_W-1:0]    occ;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign occ      = OCC_W'(count_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mem_we        = 1'b0;
        mem_waddr     = head_reg;
        mem_wdata     = value_reg;
        mem_re        = 1'b0;
        mem_raddr     = head_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    status_next = ST_DONE;
                    state_next  = S_RD_LO;
                    case (s_tuser)
                        OP_INSERT:
                        begin
                            if (count_reg >= CAP_C)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                value_next = s_tdata;
                                pos_next   = AW'(count_reg);
                                state_next = S_INS_RD;
                            end
                        end
                        OP_POP_MAX:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_MIN:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                head_next  = wrap_add(head_reg, AW'(1));
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                            head_next  = '0;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    // Reached the head: the new value becomes the smallest.
                    mem_we     = 1'b1;
                    mem_waddr  = head_reg;
                    mem_wdata  = value_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_RD_LO;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = wrap_add(head_reg, pos_reg - 1'b1);
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = wrap_add(head_reg, pos_reg);
                if (rd_data_reg > value_reg)
                begin
                    // Larger neighbor moves up one slot; keep walking down.
                    mem_wdata  = rd_data_reg;
                    pos_next   = pos_reg - 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    mem_wdata  = value_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_RD_LO;
                end
            end
            S_RD_LO:
            begin
                if (count_reg == '0)
                begin
                    lo_next    = '0;
                    hi_next    = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = head_reg;
                    state_next = S_RD_HI;
                end
            end
            S_RD_HI:
            begin
                lo_next    = rd_data_reg;
                mem_re     = 1'b1;
                mem_raddr  = wrap_add(head_reg, AW'(count_reg - 1'b1));
                state_next = S_CAP_HI;
            end
            S_CAP_HI:
            begin
                hi_next    = rd_data_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, (count_reg == '0), occ, lo_reg, hi_reg};
                    m_tuser_next  = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Value store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("queue count exceeds capacity");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[73]) |-> (m_tdata[63:0] == 64'd0))
        else $error("empty result carries nonzero values");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAP_HI) |-> (rd_data_reg >= lo_reg))
        else $error("largest value below smallest value");

    a_insert_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_RD) |-> (CW'(pos_reg) <= count_reg))
        else $error("insert position beyond tail");

endmodule
`default_nettype wire
